### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define CHK_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CHK_ASSERT(lbl, clk, rst, prop)
`define CHK_ASSERT_ALL(lbl, clk, prop)
`endif
`endif

### hw/rtl/glpa_pkg.sv
// Types and constants for the gated landmark position average block.
// No dependencies.
`timescale 1ns / 1ps
package glpa_pkg;
  localparam logic [15:0] MAX_MEAS = 16'd65535;
  localparam logic [15:0] GATE_RESET = 16'd128;

  localparam logic [1:0] STAT_ACCEPT = 2'd0;
  localparam logic [1:0] STAT_GATED  = 2'd1;
  localparam logic [1:0] STAT_ZDEPTH = 2'd2;
  localparam logic [1:0] STAT_CLEAR  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GSQ, ST_GACC, ST_TMUL, ST_TCAP, ST_TSQ, ST_TACC, ST_GCMP,
    ST_MMUL, ST_MDIV, ST_MWAIT, ST_WDIV, ST_WWAIT, ST_WMUL, ST_WACC,
    ST_EDIV, ST_EWAIT, ST_OUT
  } state_t;
endpackage

### hw/rtl/gated_landmark_position_average.sv
// Top level: gated inverse-depth weighted landmark position average.
// Depends on glpa_pkg and assert_macros.svh.
//
//   channel   signals                                      direction
//   in        in_valid, in_stall, kind, meas_x/y/z, depth  item in
//   out       out_valid, out_stall, est_x/y/z, status, ... result out
//   cfg       cfg_wr_en, cfg_wr_data (gate_ratio)          register write
//
// One transaction at a time. Clear and zero-depth items go straight to the
// result. Gate rejects and accepts at full count end after the gate test. The
// first two points run only the weight division; a gated accept runs the mean,
// weight and estimate divisions on the shared restoring divider (one quotient
// bit per cycle). rst is synchronous; in_stall is high whenever a transaction
// is in work or its result waits on out_stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gated_landmark_position_average import glpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [31:0] meas_x,
  input  logic signed [31:0] meas_y,
  input  logic signed [31:0] meas_z,
  input  logic [31:0]        depth,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] est_x,
  output logic signed [31:0] est_y,
  output logic signed [31:0] est_z,
  output logic [1:0]         status,
  output logic               validated,
  output logic [31:0]        updates_seen,
  output logic [31:0]        updates_failed
);

  state_t st, st_next;
  logic [1:0] ax, ph;
  logic [15:0] gate;
  logic [15:0] cnt;
  logic signed [31:0] mean [3];
  logic signed [31:0] est [3];
  logic signed [31:0] pin [3];
  logic [31:0] dep;
  logic [49:0] wsum;
  logic [63:0] wsums [3];
  logic [31:0] seen, failed;
  logic vflag, gated;
  logic [1:0] stat;
  logic [66:0] gsum;
  logic [47:0] treg;
  logic [95:0] tsq;
  logic [32:0] wreg;
  logic dneg;

  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_q;

  logic [49:0] div_rem, div_den;
  logic [79:0] div_num;
  logic [63:0] div_quo;
  logic [6:0]  div_cnt;
  logic [50:0] rem_sh;
  logic        rem_ge;
  logic        div_done;

  logic signed [31:0] pport [3];
  logic signed [31:0] half [3];
  logic signed [32:0] s33;
  logic signed [31:0] m_sel, p_sel;
  logic signed [32:0] dif33, dvm33, mabs33, pabs33;
  logic [48:0] sp49, num49, nmag49;
  logic [63:0] ws_sel, emag;
  logic [31:0] eq_sat;
  logic gate_pass, in_acc;

  assign pport[0] = meas_x;
  assign pport[1] = meas_y;
  assign pport[2] = meas_z;
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s33 = {mean[i][31], mean[i]} + {pport[i][31], pport[i]};
      s33 = s33 + {32'd0, s33[32]};
      half[i] = s33[32:1];
    end
    m_sel = mean[ax];
    p_sel = pin[ax];
    dif33 = {m_sel[31], m_sel} - {p_sel[31], p_sel};
    dvm33 = dif33[32] ? -dif33 : dif33;
    mabs33 = m_sel[31] ? -{m_sel[31], m_sel} : {m_sel[31], m_sel};
    pabs33 = p_sel[31] ? -{p_sel[31], p_sel} : {p_sel[31], p_sel};
    sp49 = m_sel[31] ? -{1'b0, mul_q[47:0]} : {1'b0, mul_q[47:0]};
    num49 = sp49 + {{17{p_sel[31]}}, p_sel};
    nmag49 = num49[48] ? -num49 : num49;
    ws_sel = wsums[ax];
    emag = ws_sel[63] ? -ws_sel : ws_sel;
    if (dneg) begin
      eq_sat = (div_quo > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : -div_quo[31:0];
    end else begin
      eq_sat = (div_quo > 64'h0000_0000_7fff_ffff) ? 32'h7fff_ffff : div_quo[31:0];
    end
    gate_pass = {13'd0, gsum, 16'd0} < tsq;
    rem_sh = {div_rem, div_num[79]};
    rem_ge = rem_sh >= {1'b0, div_den};
    div_done = (div_cnt == 7'd0);
  end

  // FSM outputs
  always_comb begin
    in_stall = (st != ST_IDLE);
    out_valid = (st == ST_OUT);
    mul_a = '0;
    mul_b = '0;
    case (st)
      ST_GSQ: begin
        mul_a = {1'b0, dvm33[31:0]};
        mul_b = {1'b0, dvm33[31:0]};
      end
      ST_TMUL: begin
        mul_a = {17'd0, gate};
        mul_b = {1'b0, dep};
      end
      ST_TSQ: begin
        case (ph)
          2'd0: begin
            mul_a = {1'b0, treg[31:0]};
            mul_b = {1'b0, treg[31:0]};
          end
          2'd1: begin
            mul_a = {17'd0, treg[47:32]};
            mul_b = {1'b0, treg[31:0]};
          end
          default: begin
            mul_a = {17'd0, treg[47:32]};
            mul_b = {17'd0, treg[47:32]};
          end
        endcase
      end
      ST_MMUL: begin
        mul_a = {17'd0, cnt};
        mul_b = mabs33;
      end
      ST_WMUL: begin
        mul_a = wreg;
        mul_b = pabs33;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // FSM next state
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind || depth == 32'd0) st_next = ST_OUT;
          else if (cnt < 16'd2) st_next = ST_WDIV;
          else st_next = ST_GSQ;
        end
      end
      ST_GSQ:  st_next = ST_GACC;
      ST_GACC: st_next = (ax == 2'd2) ? ST_TMUL : ST_GSQ;
      ST_TMUL: st_next = ST_TCAP;
      ST_TCAP: st_next = ST_TSQ;
      ST_TSQ:  st_next = ST_TACC;
      ST_TACC: st_next = (ph == 2'd2) ? ST_GCMP : ST_TSQ;
      ST_GCMP: st_next = (gate_pass && cnt < MAX_MEAS) ? ST_MMUL : ST_OUT;
      ST_MMUL: st_next = ST_MDIV;
      ST_MDIV: st_next = ST_MWAIT;
      ST_MWAIT: begin
        if (div_done) st_next = (ax == 2'd2) ? ST_WDIV : ST_MMUL;
      end
      ST_WDIV: st_next = ST_WWAIT;
      ST_WWAIT: begin
        if (div_done) st_next = ST_WMUL;
      end
      ST_WMUL: st_next = ST_WACC;
      ST_WACC: begin
        if (ax == 2'd2) st_next = gated ? ST_EDIV : ST_OUT;
        else st_next = ST_WMUL;
      end
      ST_EDIV: st_next = ST_EWAIT;
      ST_EWAIT: begin
        if (div_done) st_next = (ax == 2'd2) ? ST_OUT : ST_EDIV;
      end
      ST_OUT: begin
        if (!out_stall) st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
    if (rst) begin
      st <= ST_IDLE;
      div_cnt <= '0;
      gate <= GATE_RESET;
      cnt <= '0;
      wsum <= '0;
      seen <= '0;
      failed <= '0;
      vflag <= 1'b0;
      stat <= STAT_ACCEPT;
      ax <= '0;
      ph <= '0;
      gated <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        mean[i] <= '0;
        est[i] <= '0;
        wsums[i] <= '0;
      end
    end else begin
      st <= st_next;
      if (!div_done) begin
        div_rem <= rem_ge ? 50'(rem_sh - {1'b0, div_den}) : rem_sh[49:0];
        div_quo <= {div_quo[62:0], rem_ge};
        div_num <= {div_num[78:0], 1'b0};
        div_cnt <= div_cnt - 7'd1;
      end
      if (cfg_wr_en) gate <= cfg_wr_data;
      case (st)
        ST_IDLE: begin
          if (in_acc) begin
            ax <= '0;
            gsum <= '0;
            tsq <= '0;
            pin[0] <= meas_x;
            pin[1] <= meas_y;
            pin[2] <= meas_z;
            dep <= depth;
            if (kind) begin
              cnt <= '0;
              wsum <= '0;
              seen <= '0;
              failed <= '0;
              vflag <= 1'b0;
              stat <= STAT_CLEAR;
              for (int i = 0; i < 3; i++) begin
                mean[i] <= '0;
                est[i] <= '0;
                wsums[i] <= '0;
              end
            end else begin
              if (seen != 32'hffff_ffff) seen <= seen + 32'd1;
              if (depth == 32'd0) begin
                stat <= STAT_ZDEPTH;
                vflag <= 1'b0;
                if (failed != 32'hffff_ffff) failed <= failed + 32'd1;
              end else if (cnt < 16'd2) begin
                stat <= STAT_ACCEPT;
                vflag <= 1'b1;
                gated <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                  est[i] <= (cnt == 16'd0) ? pport[i] : half[i];
                  mean[i] <= (cnt == 16'd0) ? pport[i] : half[i];
                end
              end
            end
          end
        end
        ST_GACC: begin
          gsum <= gsum + {1'b0, mul_q};
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        ST_TCAP: begin
          treg <= mul_q[47:0];
          ph <= '0;
        end
        ST_TACC: begin
          case (ph)
            2'd0: tsq <= tsq + {30'd0, mul_q};
            2'd1: tsq <= tsq + {mul_q[62:0], 33'd0};
            default: tsq <= tsq + {mul_q[31:0], 64'd0};
          endcase
          ph <= ph + 2'd1;
        end
        ST_GCMP: begin
          if (gate_pass) begin
            stat <= STAT_ACCEPT;
            vflag <= 1'b1;
            gated <= 1'b1;
          end else begin
            stat <= STAT_GATED;
            vflag <= 1'b0;
            if (failed != 32'hffff_ffff) failed <= failed + 32'd1;
          end
        end
        ST_MDIV: begin
          dneg <= num49[48];
          div_num <= {nmag49[47:0], 32'd0};
          div_den <= {34'd0, cnt + 16'd1};
          div_rem <= '0;
          div_quo <= '0;
          div_cnt <= 7'd48;
        end
        ST_MWAIT: begin
          if (div_done) begin
            mean[ax] <= dneg ? -div_quo[31:0] : div_quo[31:0];
            ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
          end
        end
        ST_WDIV: begin
          div_num <= {1'b1, 79'd0};
          div_den <= {18'd0, dep};
          div_rem <= '0;
          div_quo <= '0;
          div_cnt <= 7'd33;
        end
        ST_WWAIT: begin
          if (div_done) begin
            wreg <= div_quo[32:0];
            wsum <= wsum + {17'd0, div_quo[32:0]};
          end
        end
        ST_WACC: begin
          wsums[ax] <= p_sel[31] ? wsums[ax] - {16'd0, mul_q[63:16]}
                                 : wsums[ax] + {16'd0, mul_q[63:16]};
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
          if (ax == 2'd2) cnt <= cnt + 16'd1;
        end
        ST_EDIV: begin
          dneg <= ws_sel[63];
          div_num <= {emag, 16'd0};
          div_den <= wsum;
          div_rem <= '0;
          div_quo <= '0;
          div_cnt <= 7'd80;
        end
        ST_EWAIT: begin
          if (div_done) begin
            est[ax] <= (wsum == 50'd0) ? mean[ax] : eq_sat;
            ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign est_x = est[0];
  assign est_y = est[1];
  assign est_z = est[2];
  assign status = stat;
  assign validated = vflag;
  assign updates_seen = seen;
  assign updates_failed = failed;

  `CHK_ASSERT(a_ready_no_result, clk, rst, (!in_stall) |-> !out_valid)
  `CHK_ASSERT(a_div_started, clk, rst, (st == ST_WDIV) |=> (div_cnt != 7'd0))
  `CHK_ASSERT(a_clear_zero, clk, rst,
    (out_valid && stat == STAT_CLEAR) |-> (seen == 32'd0 && failed == 32'd0))
  `CHK_ASSERT(a_failed_le_seen, clk, rst, failed <= seen)
  `CHK_ASSERT_ALL(a_rst_idle, clk, rst |=> (st == ST_IDLE))

endmodule
